### rtl/core/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg: shared constants, types and the sine table builder
// Fixed-point widths for the oriented box overlap pipeline and the
// elaboration-time quarter-wave sine table.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int ANGLE_BITS         = 12;
   localparam int TRIG_FRACTION_BITS = 15;

   localparam int QUARTER   = 1 << (ANGLE_BITS - 2);
   localparam int ROM_DEPTH = QUARTER + 1;
   localparam int ROM_AW    = $clog2(ROM_DEPTH);
   localparam int ROM_W     = TRIG_FRACTION_BITS + 1;   // 0 .. 2^F
   localparam int TRIG_W    = TRIG_FRACTION_BITS + 2;   // signed sin/cos

   localparam int COORD_W = 20;
   localparam int DIM_W   = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int AXIS_W  = TRIG_W + 1;

   // quadrant codes
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;

   localparam logic [63:0] TWO_PI_Q61 = 64'hC90FDAA22168C234;
   localparam int          Q61_SHIFT  = 61;

   typedef logic [ROM_W-1:0] rom_type [ROM_DEPTH];

   function automatic logic [63:0] mul_q61(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return 64'(p >> Q61_SHIFT);
   endfunction

   // Taylor series in Q61, rounded to F fraction bits
   function automatic rom_type build_rom();
      rom_type      t;
      logic [127:0] p;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  sum;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         p    = 128'(TWO_PI_Q61) * 128'(k);
         x    = 64'(p >> ANGLE_BITS);
         x2   = mul_q61(x, x);
         term = x;
         sum  = x;
         for (int n = 1; n <= 14; n++) begin
            term = mul_q61(term, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         sum  = (sum + (64'd1 << (Q61_SHIFT - TRIG_FRACTION_BITS - 1)))
                >> (Q61_SHIFT - TRIG_FRACTION_BITS);
         t[k] = ROM_W'(sum);
      end
      return t;
   endfunction

endpackage

### rtl/core/obb_trig.sv
// ----------------------------------------------------------------------------
// obb_trig: sine/cosine lookup
// Two-stage: registered quarter-wave ROM read, then quadrant folding.
// ----------------------------------------------------------------------------
module obb_trig (
   input  logic                                  clock,
   input  logic                                  advance,
   input  logic [obb_pkg::ANGLE_BITS-1:0]        angle,
   output logic signed [obb_pkg::TRIG_W-1:0]     cos_out,
   output logic signed [obb_pkg::TRIG_W-1:0]     sin_out
);
   import obb_pkg::*;

   localparam rom_type ROM = build_rom();

   logic [ROM_AW-1:0] addr_p;
   logic [ROM_AW-1:0] addr_m;
   logic [ROM_W-1:0]  p_ff;
   logic [ROM_W-1:0]  m_ff;
   logic [1:0]        quad_ff;
   logic signed [TRIG_W-1:0] p_val;
   logic signed [TRIG_W-1:0] m_val;
   logic signed [TRIG_W-1:0] cos_in;
   logic signed [TRIG_W-1:0] sin_in;
   logic signed [TRIG_W-1:0] cos_ff;
   logic signed [TRIG_W-1:0] sin_ff;

   assign addr_p = ROM_AW'(angle[ANGLE_BITS-3:0]);
   assign addr_m = ROM_AW'(QUARTER) - ROM_AW'(angle[ANGLE_BITS-3:0]);

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff    <= ROM[addr_p];
         m_ff    <= ROM[addr_m];
         quad_ff <= angle[ANGLE_BITS-1 -: 2];
      end
   end

   assign p_val = signed'({1'b0, p_ff});
   assign m_val = signed'({1'b0, m_ff});

   always_comb begin
      case (quad_ff)
         QUAD_0: begin
            sin_in = p_val;
            cos_in = m_val;
         end
         QUAD_1: begin
            sin_in = m_val;
            cos_in = -p_val;
         end
         QUAD_2: begin
            sin_in = -p_val;
            cos_in = -m_val;
         end
         default: begin
            sin_in = -m_val;
            cos_in = p_val;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

### rtl/core/obb_axis.sv
// ----------------------------------------------------------------------------
// obb_axis: one separating axis check
// Four stages: products, sums, magnitude scaling, total and compare.
// ----------------------------------------------------------------------------
module obb_axis (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [obb_pkg::AXIS_W-1:0]   ux,
   input  logic signed [obb_pkg::AXIS_W-1:0]   uy,
   input  logic signed [obb_pkg::DIFF_W-1:0]   dx,
   input  logic signed [obb_pkg::DIFF_W-1:0]   dy,
   input  logic signed [obb_pkg::TRIG_W-1:0]   a_cos,
   input  logic signed [obb_pkg::TRIG_W-1:0]   a_sin,
   input  logic signed [obb_pkg::TRIG_W-1:0]   b_cos,
   input  logic signed [obb_pkg::TRIG_W-1:0]   b_sin,
   input  logic [obb_pkg::DIM_W-1:0]           a_width,
   input  logic [obb_pkg::DIM_W-1:0]           a_height,
   input  logic [obb_pkg::DIM_W-1:0]           b_width,
   input  logic [obb_pkg::DIM_W-1:0]           b_height,
   input  logic                                skip,
   output logic                                overlap
);
   import obb_pkg::*;

   localparam int PD_W  = DIFF_W + AXIS_W;
   localparam int DP_W  = PD_W + 1;
   localparam int PT_W  = TRIG_W + AXIS_W;
   localparam int T_W   = PT_W + 1;
   localparam int LHS_W = DP_W + TRIG_FRACTION_BITS + 1;
   localparam int EXT_W = DIM_W + T_W;
   localparam int SUM_W = EXT_W + 2;

   // stage 1: products
   logic signed [PD_W-1:0] pdx_ff, pdy_ff;
   logic signed [PT_W-1:0] acx_ff, asy_ff, acy_ff, asx_ff;
   logic signed [PT_W-1:0] bcx_ff, bsy_ff, bcy_ff, bsx_ff;
   logic [DIM_W-1:0] aw1_ff, ah1_ff, bw1_ff, bh1_ff;
   logic skip1_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         pdx_ff  <= PD_W'(dx) * PD_W'(ux);
         pdy_ff  <= PD_W'(dy) * PD_W'(uy);
         acx_ff  <= PT_W'(a_cos) * PT_W'(ux);
         asy_ff  <= PT_W'(a_sin) * PT_W'(uy);
         acy_ff  <= PT_W'(a_cos) * PT_W'(uy);
         asx_ff  <= PT_W'(a_sin) * PT_W'(ux);
         bcx_ff  <= PT_W'(b_cos) * PT_W'(ux);
         bsy_ff  <= PT_W'(b_sin) * PT_W'(uy);
         bcy_ff  <= PT_W'(b_cos) * PT_W'(uy);
         bsx_ff  <= PT_W'(b_sin) * PT_W'(ux);
         aw1_ff  <= a_width;
         ah1_ff  <= a_height;
         bw1_ff  <= b_width;
         bh1_ff  <= b_height;
         skip1_ff <= skip;
      end
   end

   // stage 2: dot products
   logic signed [DP_W-1:0] dp_ff;
   logic signed [T_W-1:0]  atx_ff, aty_ff, btx_ff, bty_ff;
   logic [DIM_W-1:0] aw2_ff, ah2_ff, bw2_ff, bh2_ff;
   logic skip2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         dp_ff    <= DP_W'(pdx_ff) + DP_W'(pdy_ff);
         atx_ff   <= T_W'(acx_ff) + T_W'(asy_ff);
         aty_ff   <= T_W'(acy_ff) - T_W'(asx_ff);
         btx_ff   <= T_W'(bcx_ff) + T_W'(bsy_ff);
         bty_ff   <= T_W'(bcy_ff) - T_W'(bsx_ff);
         aw2_ff   <= aw1_ff;
         ah2_ff   <= ah1_ff;
         bw2_ff   <= bw1_ff;
         bh2_ff   <= bh1_ff;
         skip2_ff <= skip1_ff;
      end
   end

   // stage 3: magnitudes scaled by box dimensions
   logic [DP_W-1:0] dp_mag;
   logic [T_W-1:0]  atx_mag, aty_mag, btx_mag, bty_mag;
   logic [LHS_W-1:0] lhs_ff;
   logic [EXT_W-1:0] e0_ff, e1_ff, e2_ff, e3_ff;
   logic skip3_ff;

   assign dp_mag  = dp_ff[DP_W-1]  ? DP_W'(-dp_ff)  : DP_W'(dp_ff);
   assign atx_mag = atx_ff[T_W-1]  ? T_W'(-atx_ff)  : T_W'(atx_ff);
   assign aty_mag = aty_ff[T_W-1]  ? T_W'(-aty_ff)  : T_W'(aty_ff);
   assign btx_mag = btx_ff[T_W-1]  ? T_W'(-btx_ff)  : T_W'(btx_ff);
   assign bty_mag = bty_ff[T_W-1]  ? T_W'(-bty_ff)  : T_W'(bty_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         lhs_ff   <= {dp_mag, {(TRIG_FRACTION_BITS + 1){1'b0}}};
         e0_ff    <= EXT_W'(aw2_ff) * EXT_W'(atx_mag);
         e1_ff    <= EXT_W'(ah2_ff) * EXT_W'(aty_mag);
         e2_ff    <= EXT_W'(bw2_ff) * EXT_W'(btx_mag);
         e3_ff    <= EXT_W'(bh2_ff) * EXT_W'(bty_mag);
         skip3_ff <= skip2_ff;
      end
   end

   // stage 4: total extent and compare; touching counts as overlap
   logic [SUM_W-1:0] ext_sum;
   logic overlap_in;
   logic overlap_ff;

   assign ext_sum    = SUM_W'(e0_ff) + SUM_W'(e1_ff) + SUM_W'(e2_ff) + SUM_W'(e3_ff);
   assign overlap_in = skip3_ff | (lhs_ff <= LHS_W'(ext_sum));

   always_ff @(posedge clock) begin
      if (advance) begin
         overlap_ff <= overlap_in;
      end
   end

   assign overlap = overlap_ff;

endmodule

### rtl/core/oriented_box_overlap_test.sv
// ----------------------------------------------------------------------------
// oriented_box_overlap_test: 2-D separating axis test for two rotated boxes
// Streams box pairs and returns one intersects flag per pair.
// ----------------------------------------------------------------------------
//
//   channel | direction | ports                         | transfer when
//   --------+-----------+-------------------------------+--------------------------
//   req     | in        | req_valid/req_stall + 10 flds | req_valid & !req_stall
//   rsp     | out       | rsp_valid/rsp_stall + flag    | rsp_valid & !rsp_stall
//
// One pair enters every cycle unless req_stall is high; a transferred request
// reaches the response register through 2 trig stages, 4 axis stages and 1 output stage.
// The whole pipeline advances as one; it freezes only when the response
// register holds a result that the sink stalls, and req_stall follows that.
// Synchronous active-high reset clears the valid bits; data needs no reset.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [obb_pkg::COORD_W-1:0]   req_a_center_x,
   input  logic signed [obb_pkg::COORD_W-1:0]   req_a_center_y,
   input  logic [obb_pkg::DIM_W-1:0]            req_a_width,
   input  logic [obb_pkg::DIM_W-1:0]            req_a_height,
   input  logic [11:0]                          req_a_angle,
   input  logic signed [obb_pkg::COORD_W-1:0]   req_b_center_x,
   input  logic signed [obb_pkg::COORD_W-1:0]   req_b_center_y,
   input  logic [obb_pkg::DIM_W-1:0]            req_b_width,
   input  logic [obb_pkg::DIM_W-1:0]            req_b_height,
   input  logic [11:0]                          req_b_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_intersects
);
   import obb_pkg::*;

   localparam int LATENCY = 7;

   // global pipeline enable
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // valid bits travel alongside the data
   logic [LATENCY-1:0] vld_ff;
   logic [LATENCY-1:0] vld_in;
   assign vld_in = {vld_ff[LATENCY-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end
   assign rsp_valid = vld_ff[LATENCY-1];

   // sin/cos for each box (2 stages)
   logic signed [TRIG_W-1:0] a_cos, a_sin, b_cos, b_sin;

   obb_trig u_trig_a (
      .clock   (clock),
      .advance (advance),
      .angle   (req_a_angle[ANGLE_BITS-1:0]),
      .cos_out (a_cos),
      .sin_out (a_sin)
   );

   obb_trig u_trig_b (
      .clock   (clock),
      .advance (advance),
      .angle   (req_b_angle[ANGLE_BITS-1:0]),
      .cos_out (b_cos),
      .sin_out (b_sin)
   );

   // center difference and dimensions, delayed to line up with trig
   logic signed [DIFF_W-1:0] dx_in, dy_in;
   logic signed [DIFF_W-1:0] dx0_ff, dy0_ff, dx1_ff, dy1_ff;
   logic [DIM_W-1:0] aw0_ff, ah0_ff, bw0_ff, bh0_ff;
   logic [DIM_W-1:0] aw1_ff, ah1_ff, bw1_ff, bh1_ff;

   assign dx_in = DIFF_W'(req_b_center_x) - DIFF_W'(req_a_center_x);
   assign dy_in = DIFF_W'(req_b_center_y) - DIFF_W'(req_a_center_y);

   always_ff @(posedge clock) begin
      if (advance) begin
         dx0_ff <= dx_in;
         dy0_ff <= dy_in;
         aw0_ff <= req_a_width;
         ah0_ff <= req_a_height;
         bw0_ff <= req_b_width;
         bh0_ff <= req_b_height;
         dx1_ff <= dx0_ff;
         dy1_ff <= dy0_ff;
         aw1_ff <= aw0_ff;
         ah1_ff <= ah0_ff;
         bw1_ff <= bw0_ff;
         bh1_ff <= bh0_ff;
      end
   end

   // four axes: per box, edge normals (s,-c) and (c,s), unnormalized.
   // A degenerate edge (zero height or width) never separates.
   logic signed [AXIS_W-1:0] ux [4];
   logic signed [AXIS_W-1:0] uy [4];
   logic [3:0] skip;
   logic [3:0] overlap;

   assign ux[0] = AXIS_W'(a_sin);
   assign uy[0] = -AXIS_W'(a_cos);
   assign ux[1] = AXIS_W'(a_cos);
   assign uy[1] = AXIS_W'(a_sin);
   assign ux[2] = AXIS_W'(b_sin);
   assign uy[2] = -AXIS_W'(b_cos);
   assign ux[3] = AXIS_W'(b_cos);
   assign uy[3] = AXIS_W'(b_sin);

   assign skip[0] = (ah1_ff == '0);
   assign skip[1] = (aw1_ff == '0);
   assign skip[2] = (bh1_ff == '0);
   assign skip[3] = (bw1_ff == '0);

   for (genvar i = 0; i < 4; i++) begin : g_axis
      obb_axis u_axis (
         .clock    (clock),
         .advance  (advance),
         .ux       (ux[i]),
         .uy       (uy[i]),
         .dx       (dx1_ff),
         .dy       (dy1_ff),
         .a_cos    (a_cos),
         .a_sin    (a_sin),
         .b_cos    (b_cos),
         .b_sin    (b_sin),
         .a_width  (aw1_ff),
         .a_height (ah1_ff),
         .b_width  (bw1_ff),
         .b_height (bh1_ff),
         .skip     (skip[i]),
         .overlap  (overlap[i])
      );
   end

   // response register: boxes intersect unless some axis separates them
   logic intersects_ff;
   logic intersects_in;
   assign intersects_in = &overlap;

   always_ff @(posedge clock) begin
      if (advance) begin
         intersects_ff <= intersects_in;
      end
   end

   assign rsp_intersects = intersects_ff;

endmodule
